>>> sv/checked_int64_alu_assert.svh
// Assertion macros for the checked ALU back end.
// No dependencies; included inside module bodies.
`ifndef CHECKED_INT64_ALU_ASSERT_SVH
`define CHECKED_INT64_ALU_ASSERT_SVH

// Implication that must hold in the next cycle.
`define CIA_ASSERT_NEXT(label, rst_n, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication in the same cycle.
`define CIA_ASSERT_NOW(label, rst_n, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/cia_pkg.sv
// Types and constants for the checked 64-bit integer ALU.
// No dependencies.
`timescale 1ns / 1ps
package cia_pkg;
    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_EQ  = 4'd4, OP_NE  = 4'd5, OP_LT  = 4'd6, OP_LE  = 4'd7,
        OP_GT  = 4'd8, OP_GE  = 4'd9
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2, ST_UNSUP = 2'd3
    } t_status;

    // Class of work handed from front to back.
    typedef enum logic [1:0] {
        CL_FAST = 2'd0, CL_MUL = 2'd1, CL_DIV = 2'd2
    } t_class;

    localparam int unsigned DivSteps = 64;

    // Word queued between front and back.
    typedef struct packed {
        t_class      cls;
        logic [1:0]  status;
        logic        is_boolean;
        logic [63:0] value;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic        neg;
    } t_task;
endpackage

>>> sv/cia_if.sv
// Valid/ready channel interfaces for the checked ALU.
// Depends on nothing.
`timescale 1ns / 1ps
interface cia_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic signed [63:0] left_operand;
    logic signed [63:0] right_operand;
    modport source(output valid, opcode, left_operand, right_operand, input ready);
    modport sink(input valid, opcode, left_operand, right_operand, output ready);
    modport monitor(input valid, ready, opcode, left_operand, right_operand);
endinterface

interface cia_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        is_boolean;
    logic signed [63:0] result_value;
    modport source(output valid, status, is_boolean, result_value, input ready);
    modport sink(input valid, status, is_boolean, result_value, output ready);
    modport monitor(input valid, ready, status, is_boolean, result_value);
endinterface

>>> sv/cia_front.sv
// Front end: accepts words, resolves simple ops, classifies mul/div.
// Depends on cia_pkg.
`timescale 1ns / 1ps
module cia_front
    import cia_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    cia_in_if.sink  i_in,
    output logic    o_valid,
    output t_task   o_task,
    input  logic    i_ready
);
    t_task  r_task, n_task;
    logic   r_valid;
    logic [63:0] a, b, sum, dif;
    logic   lt, eq;

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_task  = r_task;

    // Classify and compute the results that need no multiply or divide.
    always_comb begin
        a   = i_in.left_operand;
        b   = i_in.right_operand;
        sum = a + b;
        dif = a - b;
        eq  = (a == b);
        lt  = (a[63] != b[63]) ? a[63] : (a < b);
        n_task = '0;
        n_task.cls = CL_FAST;
        n_task.mag_a = a[63] ? (~a + 64'd1) : a;
        n_task.mag_b = b[63] ? (~b + 64'd1) : b;
        n_task.neg = a[63] ^ b[63];
        unique case (i_in.opcode)
            OP_ADD: begin
                if (a[63] == b[63] && sum[63] != a[63]) n_task.status = ST_OVF;
                else n_task.value = sum;
            end
            OP_SUB: begin
                if (a[63] != b[63] && dif[63] != a[63]) n_task.status = ST_OVF;
                else n_task.value = dif;
            end
            OP_MUL: n_task.cls = CL_MUL;
            OP_DIV: begin
                if (b == '0) n_task.status = ST_DIV0;
                else if (a == {1'b1, 63'd0} && b == '1) n_task.status = ST_OVF;
                else n_task.cls = CL_DIV;
            end
            OP_EQ: begin n_task.is_boolean = 1'b1; n_task.value = {63'd0, eq}; end
            OP_NE: begin n_task.is_boolean = 1'b1; n_task.value = {63'd0, !eq}; end
            OP_LT: begin n_task.is_boolean = 1'b1; n_task.value = {63'd0, lt}; end
            OP_LE: begin n_task.is_boolean = 1'b1; n_task.value = {63'd0, lt || eq}; end
            OP_GT: begin n_task.is_boolean = 1'b1; n_task.value = {63'd0, !(lt || eq)}; end
            OP_GE: begin n_task.is_boolean = 1'b1; n_task.value = {63'd0, !lt}; end
            default: n_task.status = ST_UNSUP;
        endcase
    end

    // Hold the classified word until the queue takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_task <= n_task;
        end
    end
endmodule

>>> sv/cia_queue.sv
// Short FIFO decoupling the front end from the back end.
// Depends on cia_pkg.
`timescale 1ns / 1ps
module cia_queue
    import cia_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_task i_task,
    output logic  o_ready,
    output logic  o_valid,
    output t_task o_task,
    input  logic  i_ready
);
    t_task r_mem [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    logic  push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_task  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    // Advance pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_task;
    end
endmodule

>>> sv/cia_back.sv
// Back end: multiply from registered partial products, iterative divide, output register.
// Depends on cia_pkg and the assertion macro header.
`timescale 1ns / 1ps
module cia_back
    import cia_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_task   i_task,
    output logic    o_ready,
    cia_out_if.source o_out
);
    `include "checked_int64_alu_assert.svh"

    typedef enum logic [1:0] {S_RUN, S_MUL, S_DIV} t_state;
    t_state r_state;

    logic [1:0]   r_status;
    logic         r_isb, r_val;
    logic [63:0]  r_res;
    logic         r_neg;
    logic [63:0]  r_b;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [63:0]  r_q, r_r;
    logic [6:0]   r_cnt;
    logic         out_free, take, fin;
    logic [64:0]  rem_sh, rem_sub;
    logic [63:0]  mid, lo, hi;
    logic         ovf;

    assign out_free = !r_val || o_out.ready;
    assign o_ready  = (r_state == S_RUN) && out_free;
    assign take     = i_valid && o_ready;
    assign o_out.valid = r_val;
    assign o_out.status = r_status;
    assign o_out.is_boolean = r_isb;
    assign o_out.result_value = r_res;

    // Combine partial products and divide step.
    always_comb begin
        mid = {32'd0, r_p00[63:32]} + {32'd0, r_p01[31:0]} + {32'd0, r_p10[31:0]};
        lo  = {mid[31:0], r_p00[31:0]};
        hi  = r_p11 + {32'd0, r_p01[63:32]} + {32'd0, r_p10[63:32]} + {32'd0, mid[63:32]};
        ovf = (hi != '0) || (r_neg ? (lo > {1'b1, 63'd0}) : lo[63]);
        rem_sh  = {r_r, r_q[63]};
        rem_sub = rem_sh - {1'b0, r_b};
    end

    // Flag a word that finishes this cycle.
    always_comb begin
        fin = (r_state == S_RUN && take && i_task.cls != CL_MUL && i_task.cls != CL_DIV)
            || (r_state == S_MUL)
            || (r_state == S_DIV && r_cnt == '0);
    end

    // Hold state, sequence mul/div and register the output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_val   <= 1'b0;
        end else begin
            r_val <= fin || (r_val && !o_out.ready);
            unique case (r_state)
                S_RUN: begin
                    if (take) begin
                        r_neg  <= i_task.neg;
                        unique case (i_task.cls)
                            CL_MUL: begin
                                r_p00 <= 64'(i_task.mag_a[31:0]) * 64'(i_task.mag_b[31:0]);
                                r_p01 <= 64'(i_task.mag_a[31:0]) * 64'(i_task.mag_b[63:32]);
                                r_p10 <= 64'(i_task.mag_a[63:32]) * 64'(i_task.mag_b[31:0]);
                                r_p11 <= 64'(i_task.mag_a[63:32]) * 64'(i_task.mag_b[63:32]);
                                r_state <= S_MUL;
                            end
                            CL_DIV: begin
                                r_q   <= i_task.mag_a;
                                r_b   <= i_task.mag_b;
                                r_r   <= '0;
                                r_cnt <= 7'(DivSteps);
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_status <= i_task.status;
                                r_isb    <= i_task.is_boolean;
                                r_res    <= i_task.value;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_isb    <= 1'b0;
                    r_status <= ovf ? ST_OVF : ST_OK;
                    r_res    <= ovf ? '0 : (r_neg ? (~lo + 64'd1) : lo);
                    r_state  <= S_RUN;
                end
                default: begin
                    if (r_cnt != '0) begin
                        if (!rem_sub[64]) r_r <= rem_sub[63:0];
                        else r_r <= rem_sh[63:0];
                        r_q <= {r_q[62:0], !rem_sub[64]};
                        r_cnt <= r_cnt - 7'd1;
                    end else begin
                        r_isb    <= 1'b0;
                        r_status <= ST_OK;
                        r_res    <= r_neg ? (~r_q + 64'd1) : r_q;
                        r_state  <= S_RUN;
                    end
                end
            endcase
        end
    end

    `CIA_ASSERT_NOW(a_ready_idle, i_rst_n, o_ready, r_state == S_RUN, "ready outside run")
    `CIA_ASSERT_NEXT(a_mul_done, i_rst_n, r_state == S_MUL, r_val && r_state == S_RUN, "mul late")
    `CIA_ASSERT_NEXT(a_hold, i_rst_n, r_val && !o_out.ready, r_val && $stable(r_res), "out lost")
endmodule

>>> sv/checked_int64_alu.sv
// Top level of the checked 64-bit integer ALU.
// Depends on cia_pkg, cia_if, cia_front, cia_queue, cia_back.
`timescale 1ns / 1ps
// Takes one operation word per cycle unless the input stalls and returns one result
// word per operation, in order. Add, sub, compares and all error cases but multiply
// overflow are resolved in the front end and stream at one word per cycle unless
// stalled; their result passes the front register, a queue entry and the output
// register. Multiply forms four 32x32 partial products and combines them the next
// cycle; the back end takes no new word meanwhile. Divide runs a restoring radix-2
// divider, one quotient bit a cycle; the back end takes no new word until it is
// done. While the back end is busy, the front register and the two-entry queue take
// up to three more words before the input stalls; a stalled output holds its word.
module checked_int64_alu
    import cia_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cia_in_if.sink     i_in,
    cia_out_if.source  o_out
);
    logic  f_valid, f_ready, q_valid, q_ready;
    t_task f_task, q_task;

    cia_front u_front (
        .i_clk, .i_rst_n, .i_in,
        .o_valid(f_valid), .o_task(f_task), .i_ready(f_ready)
    );
    cia_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .i_task(f_task), .o_ready(f_ready),
        .o_valid(q_valid), .o_task(q_task), .i_ready(q_ready)
    );
    cia_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .i_task(q_task), .o_ready(q_ready), .o_out
    );
endmodule

>>> bench/checked_int64_alu_chk.sv
// Checker for the checked 64-bit integer ALU: predicts each accepted word and
// compares results in order. Depends on cia_pkg and cia_if.
`timescale 1ns / 1ps
module checked_int64_alu_chk
    import cia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cia_in_if.monitor   i_in,
    cia_out_if.monitor  i_out,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct {
        logic [1:0]  status;
        logic        is_boolean;
        logic [63:0] value;
    } t_alu_result;

    t_alu_result expected_results[$];
    int mismatches;

    // Compute the result of one operation word.
    function automatic t_alu_result alu_predict(logic [3:0] op, logic signed [63:0] a,
                                                logic signed [63:0] b);
        t_alu_result r;
        logic signed [127:0] wide;
        logic signed [64:0] sum;
        r.status = ST_OK;
        r.is_boolean = 1'b0;
        r.value = '0;
        case (op)
            OP_ADD, OP_SUB: begin
                sum = (op == OP_ADD) ? (65'(a) + 65'(b)) : (65'(a) - 65'(b));
                if (sum[64] != sum[63]) r.status = ST_OVF;
                else r.value = sum[63:0];
            end
            OP_MUL: begin
                wide = 128'(a) * 128'(b);
                if (wide > 128'sh7fffffffffffffff || wide < -128'sh8000000000000000)
                    r.status = ST_OVF;
                else r.value = wide[63:0];
            end
            OP_DIV: begin
                if (b == 0) r.status = ST_DIV0;
                else if (a == 64'sh8000000000000000 && b == -64'sd1) r.status = ST_OVF;
                else r.value = a / b;
            end
            OP_EQ: begin r.is_boolean = 1'b1; r.value = 64'(a == b); end
            OP_NE: begin r.is_boolean = 1'b1; r.value = 64'(a != b); end
            OP_LT: begin r.is_boolean = 1'b1; r.value = 64'(a < b); end
            OP_LE: begin r.is_boolean = 1'b1; r.value = 64'(a <= b); end
            OP_GT: begin r.is_boolean = 1'b1; r.value = 64'(a > b); end
            OP_GE: begin r.is_boolean = 1'b1; r.value = 64'(a >= b); end
            default: r.status = ST_UNSUP;
        endcase
        return r;
    endfunction

    assign o_fail_count = mismatches;
    assign o_pending = expected_results.size();

    // Queue predictions and compare each result word with the oldest one.
    always @(posedge i_clk) begin
        t_alu_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            mismatches <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                expected_results.push_back(alu_predict(i_in.opcode, i_in.left_operand,
                                                       i_in.right_operand));
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) $display("result word with nothing expected");
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_out.status || want.is_boolean !== i_out.is_boolean
                        || want.value !== i_out.result_value) begin
                        if (mismatches < 10)
                            $display("mismatch: exp st=%0d b=%0d v=%h got st=%0d b=%0d v=%h",
                                     want.status, want.is_boolean, want.value,
                                     i_out.status, i_out.is_boolean, i_out.result_value);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

>>> bench/checked_int64_alu_tb.sv
// Testbench top for the checked 64-bit integer ALU: drives directed and random
// operation words with random idling. Depends on cia_pkg, cia_if, checked_int64_alu_chk.
`timescale 1ns / 1ps
module checked_int64_alu_tb;
    import cia_pkg::*;

    localparam logic [63:0] MinVal = 64'h8000000000000000;
    localparam logic [63:0] MaxVal = 64'h7fffffffffffffff;
    localparam logic [63:0] MinusOne = '1;
    localparam logic [3:0]  OpUnsupLow = 4'd10;
    localparam logic [3:0]  OpUnsupHigh = 4'd15;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   src_idle_pct;
    int   snk_idle_pct;

    cia_in_if  in_ch();
    cia_out_if out_ch();

    checked_int64_alu dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));

    checked_int64_alu_chk chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch),
                               .i_out(out_ch), .o_fail_count(fail_count),
                               .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Pick an interesting operand: extremes, small values, shifted random values, or fully random.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(9))
            0: return MinVal;
            1: return MaxVal;
            2: return MinusOne;
            3: return 64'(signed'($urandom_range(8)) - 4);
            4: return 64'(signed'($urandom)) ;
            5: return {32'h0, $urandom} >> $urandom_range(31);
            6: return {$urandom, $urandom} >> $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word and hold it until accepted, with random gaps before it.
    task automatic send_word(logic [3:0] op, logic [63:0] a, logic [63:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.left_operand <= a;
        in_ch.right_operand <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic random_words(int n);
        logic [3:0] op;
        logic [63:0] a;
        logic [63:0] b;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
            a = pick_operand();
            b = pick_operand();
            // Bias compares toward equal operands so both outcomes occur.
            if (op >= OP_EQ && op <= OP_GE && $urandom_range(3) == 0) b = a;
            // Divides are not filtered: the divider always runs all DivSteps steps.
            send_word(op, a, b);
        end
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.left_operand = '0;
        in_ch.right_operand = '0;
        src_idle_pct = 34;
        snk_idle_pct = 52;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation at the extremes and each special case.
        send_word(OP_ADD, MaxVal, 64'd1);
        send_word(OP_ADD, MinVal, MinusOne);
        send_word(OP_ADD, MaxVal, MinVal);
        send_word(OP_SUB, MinVal, 64'd1);
        send_word(OP_SUB, MaxVal, MinusOne);
        send_word(OP_SUB, 64'd0, MinVal);
        send_word(OP_MUL, MinVal, 64'd1);
        send_word(OP_MUL, MinVal, MinusOne);
        send_word(OP_MUL, 64'h0000000100000000, 64'hffffffff80000000);
        send_word(OP_MUL, 64'h0000000100000000, 64'h0000000080000000);
        send_word(OP_MUL, MaxVal, MaxVal);
        send_word(OP_DIV, 64'd7, 64'd0);
        send_word(OP_DIV, MinVal, 64'd0);
        send_word(OP_DIV, MinVal, MinusOne);
        send_word(OP_DIV, 64'hfffffffffffffff9, 64'd2);
        send_word(OP_DIV, MinVal, MaxVal);
        send_word(OP_EQ, MinVal, MinVal);
        send_word(OP_NE, MinVal, MaxVal);
        send_word(OP_LT, MinVal, MaxVal);
        send_word(OP_LE, MaxVal, MaxVal);
        send_word(OP_GT, MinusOne, 64'd0);
        send_word(OP_GE, MinVal, MaxVal);
        send_word(OpUnsupLow, MaxVal, MaxVal);
        send_word(OpUnsupHigh, MinVal, MinVal);

        // Random words in three idling phases.
        random_words(650);
        src_idle_pct = 52;
        snk_idle_pct = 34;
        random_words(650);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_words(650);
        in_ch.valid <= 1'b0;

        // Drain, then wait on to catch any extra result word.
        waited = 0;
        while (pending != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS checked_int64_alu");
        end else begin
            $display("FAIL checked_int64_alu");
        end
        $finish;
    end

    // Hard limit well above the slowest run (every word a divide under stalls).
    initial begin
        #20ms;
        $display("FAIL checked_int64_alu");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/cia_pkg.sv
sv/cia_if.sv
sv/cia_front.sv
sv/cia_queue.sv
sv/cia_back.sv
sv/checked_int64_alu.sv
bench/checked_int64_alu_chk.sv
bench/checked_int64_alu_tb.sv
